### hw/rtl/lru_set_assoc_cache_model_assert.svh
// Assertion macros used by the checker file of this block.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef LRU_SET_ASSOC_CACHE_MODEL_ASSERT_SVH
`define LRU_SET_ASSOC_CACHE_MODEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru cache assertion failed");

`endif

### hw/rtl/lru_sac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_sac_pkg;

   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned OUTCOME_W  = 2;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned SET_BITS_W   = 3;
   localparam int unsigned BLOCK_BITS_W = 5;
   localparam int unsigned WAYS_W       = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_MISS  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS       = 2'd2;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RESET   = 3'd0;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 5'd0;
   localparam logic [WAYS_W-1:0]       WAYS_RESET       = 4'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REREAD,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Counter increment that sticks at all ones.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      return (value == '1) ? value : value + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lru_sac_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lru_sac_req_if import lru_sac_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output command, output address, input ready);
   modport sink (input valid, input command, input address, output ready);
endinterface

`default_nettype wire

### hw/rtl/lru_sac_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lru_sac_rsp_if import lru_sac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic [COUNT_W-1:0]   hit_count;
   logic [COUNT_W-1:0]   miss_count;
   logic [COUNT_W-1:0]   eviction_count;
   logic                 last;

   modport source (output valid, output outcome, output hit_count, output miss_count,
                   output eviction_count, output last, input ready);
   modport sink (input valid, input outcome, input hit_count, input miss_count,
                 input eviction_count, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/lru_set_assoc_cache_model.sv
`timescale 1ns / 1ps
`default_nettype none

// Set-associative cache tag model with true LRU replacement. Each request transfer carries
// a command (load, store or modify) and a 32-bit byte address; a load or store makes one
// cache access and one response transfer, a modify makes two accesses to the same address
// and two response transfers, the second one marked last, and the unused command code is
// taken and dropped without a response. Every response gives the outcome (hit, miss into a
// free way, or miss with eviction) and the running hit, miss and eviction counts, which
// saturate at all ones. The set rows live in one memory of 2**MAX_SET_BITS rows; each row
// holds valid, tag and age for MAX_WAYS ways. After reset a clearing pass writes every row
// to zero, one row a cycle, so the request side stays not ready until that pass is done;
// CSR writes are taken during that time. An access reads its row in the cycle the
// request is accepted, then a single tag and age comparator walks the active ways one per
// cycle (stopping at the first hit), and an update state writes the row back and loads the
// response register. A request is only taken in the idle state, so the block finishes one
// access (both of a modify) before it takes the next. It takes a new request while the
// previous response still waits, but a row write-back waits until the response register
// is free.
module lru_set_assoc_cache_model import lru_sac_pkg::*; #(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS     = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lru_sac_req_if.sink                req_bus,
   lru_sac_rsp_if.source              rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
   localparam int unsigned SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int unsigned WAY_AW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned WAY_CW   = $clog2(MAX_WAYS + 1);
   localparam int unsigned AGE_W    = WAY_AW;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   // One memory row is one whole set.
   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
      logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
   } row_type;

   // CSR registers and the values the access path actually uses.
   logic [SET_BITS_W-1:0]   set_bits_ff, set_bits_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [WAYS_W-1:0]       ways_ff, ways_in;
   logic                    csr_write;
   logic [1:0]              csr_index;
   logic [3:0]              set_bits_eff;
   logic [WAY_CW-1:0]       ways_eff;

   // Address split.
   logic [5:0]        shift_sum;
   logic [ADDR_W-1:0] tag_calc;
   logic [ADDR_W-1:0] set_shift;
   logic [SET_AW:0]   set_mask_wide;
   logic [SET_AW-1:0] set_calc;
   logic              cmd_ok;

   // Sequencer and per-access registers.
   state_type         state_ff, state_in;
   logic [SET_AW-1:0] clr_ff, clr_in;
   logic              clr_last;
   logic [ADDR_W-1:0] tag_ff, tag_in;
   logic [SET_AW-1:0] set_ff, set_in;
   logic              pending_ff, pending_in;
   logic              scan_start;

   // Scan state of the shared comparator.
   logic [WAY_AW-1:0] way_ff, way_in;
   logic              hit_ff, hit_in;
   logic [WAY_AW-1:0] hit_way_ff, hit_way_in;
   logic [AGE_W-1:0]  hit_age_ff, hit_age_in;
   logic              free_ff, free_in;
   logic [WAY_AW-1:0] free_way_ff, free_way_in;
   logic [AGE_W-1:0]  best_age_ff, best_age_in;
   logic [WAY_AW-1:0] best_way_ff, best_way_in;
   logic              cur_valid;
   logic [ADDR_W-1:0] cur_tag;
   logic [AGE_W-1:0]  cur_age;
   logic              tag_match;
   logic              scan_last;

   // Row memory.
   row_type           row_mem [NUM_SETS];
   row_type           rd_row_ff;
   logic              mem_re;
   logic [SET_AW-1:0] mem_raddr;
   logic              mem_we;
   logic [SET_AW-1:0] mem_waddr;
   row_type           mem_wdata;
   row_type           new_row;
   logic [WAY_AW-1:0] victim_way;

   // Counters and response register.
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   misses_ff, misses_in;
   logic [COUNT_W-1:0]   evictions_ff, evictions_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic                 last_ff, last_in;
   logic                 out_free;

   // ---------------------------------------------------------------------------------
   // CSR port. Writes land on the access-phase edge; pready is tied high so there are
   // no wait states. Byte address bits [1:0] are ignored.
   // ---------------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SET_BITS:   set_bits_in   = csr_pwdata[SET_BITS_W-1:0];
            REG_BLOCK_BITS: block_bits_in = csr_pwdata[BLOCK_BITS_W-1:0];
            REG_WAYS:       ways_in       = csr_pwdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SET_BITS:   csr_prdata = CSR_DATA_W'(set_bits_ff);
         REG_BLOCK_BITS: csr_prdata = CSR_DATA_W'(block_bits_ff);
         REG_WAYS:       csr_prdata = CSR_DATA_W'(ways_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Out-of-range settings are clamped here: set bits to MAX_SET_BITS, and ways into
   // the range one to MAX_WAYS.
   assign set_bits_eff = (32'(set_bits_ff) > MAX_SET_BITS) ? 4'(MAX_SET_BITS)
                                                           : 4'(set_bits_ff);

   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WAY_CW'(1);
      end else if (32'(ways_ff) > MAX_WAYS) begin
         ways_eff = WAY_CW'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CW'(ways_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // Address split. The tag is the address above the set and block bits, and zero when
   // those bits cover the whole address.
   // ---------------------------------------------------------------------------------
   assign shift_sum     = 6'(set_bits_eff) + 6'(block_bits_ff);
   assign tag_calc      = shift_sum[5] ? '0 : (req_bus.address >> shift_sum[4:0]);
   assign set_shift     = req_bus.address >> block_bits_ff;
   assign set_mask_wide = ((SET_AW + 1)'(1) << set_bits_eff) - (SET_AW + 1)'(1);
   assign set_calc      = set_shift[SET_AW-1:0] & set_mask_wide[SET_AW-1:0];
   assign cmd_ok        = req_bus.command inside {CMD_LOAD, CMD_STORE, CMD_MODIFY};

   // ---------------------------------------------------------------------------------
   // Row memory: one write port, one registered read port. The read register only
   // loads when a lookup starts, so it holds the row for the whole scan.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_row_ff <= row_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------------------
   // Shared comparator: looks at one way of the held row per cycle.
   // ---------------------------------------------------------------------------------
   assign cur_valid = rd_row_ff.valid[way_ff];
   assign cur_tag   = rd_row_ff.tag[way_ff];
   assign cur_age   = rd_row_ff.age[way_ff];
   assign tag_match = cur_valid && (cur_tag == tag_ff);
   assign scan_last = (WAY_CW'(way_ff) + WAY_CW'(1)) == ways_eff;

   // The line that ends up most recent: the hit way, else the lowest free way, else the
   // oldest line (lowest way on a tie).
   assign victim_way = hit_ff ? hit_way_ff : (free_ff ? free_way_ff : best_way_ff);

   // Age update across the active ways of the row. On a hit, only lines younger than
   // the hit line get older; on a miss, every other valid line gets older.
   always_comb begin
      new_row = rd_row_ff;
      for (int k = 0; k < MAX_WAYS; k++) begin
         if ((WAY_CW'(k) < ways_eff) && (WAY_AW'(k) != victim_way) && rd_row_ff.valid[k]) begin
            if (!hit_ff || (rd_row_ff.age[k] < hit_age_ff)) begin
               if (rd_row_ff.age[k] < AGE_MAX) begin
                  new_row.age[k] = rd_row_ff.age[k] + AGE_W'(1);
               end
            end
         end
      end
      new_row.valid[victim_way] = 1'b1;
      new_row.tag[victim_way]   = tag_ff;
      new_row.age[victim_way]   = '0;
   end

   // ---------------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------------
   assign clr_last      = (clr_ff == SET_AW'(NUM_SETS - 1));
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid && cmd_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_REREAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tag_match || scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = pending_ff ? ST_REREAD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      mem_re       = 1'b0;
      mem_raddr    = set_ff;
      mem_we       = 1'b0;
      mem_waddr    = set_ff;
      mem_wdata    = new_row;
      clr_in       = clr_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      pending_in   = pending_ff;
      scan_start   = 1'b0;
      way_in       = way_ff;
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      hit_age_in   = hit_age_ff;
      free_in      = free_ff;
      free_way_in  = free_way_ff;
      best_age_in  = best_age_ff;
      best_way_in  = best_way_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evictions_in = evictions_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      outcome_in   = outcome_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + SET_AW'(1);
         end
         ST_IDLE: begin
            if (req_bus.valid && cmd_ok) begin
               tag_in     = tag_calc;
               set_in     = set_calc;
               mem_re     = 1'b1;
               mem_raddr  = set_calc;
               pending_in = (req_bus.command == CMD_MODIFY);
               scan_start = 1'b1;
            end
         end
         ST_REREAD: begin
            // Second access of a modify, after the first one has been written back.
            mem_re     = 1'b1;
            scan_start = 1'b1;
         end
         ST_SCAN: begin
            way_in = way_ff + WAY_AW'(1);
            if (tag_match) begin
               hit_in     = 1'b1;
               hit_way_in = way_ff;
               hit_age_in = cur_age;
            end
            if (!cur_valid && !free_ff) begin
               free_in     = 1'b1;
               free_way_in = way_ff;
            end
            if (cur_age > best_age_ff) begin
               best_age_in = cur_age;
               best_way_in = way_ff;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               last_in      = !pending_ff;
               pending_in   = 1'b0;
               if (hit_ff) begin
                  hits_in    = sat_inc(hits_ff);
                  outcome_in = OUTCOME_HIT;
               end else if (free_ff) begin
                  misses_in  = sat_inc(misses_ff);
                  outcome_in = OUTCOME_MISS;
               end else begin
                  misses_in    = sat_inc(misses_ff);
                  evictions_in = sat_inc(evictions_ff);
                  outcome_in   = OUTCOME_EVICT;
               end
            end
         end
         default: ;
      endcase

      if (scan_start) begin
         way_in      = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         best_age_in = '0;
         best_way_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evictions_ff  <= '0;
         set_bits_ff   <= SET_BITS_RESET;
         block_bits_ff <= BLOCK_BITS_RESET;
         ways_ff       <= WAYS_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evictions_ff  <= evictions_in;
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      set_ff      <= set_in;
      way_ff      <= way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      hit_age_ff  <= hit_age_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
      best_age_ff <= best_age_in;
      best_way_ff <= best_way_in;
      outcome_ff  <= outcome_in;
      last_ff     <= last_in;
   end

   // The counters only move when the response register is loaded, so they can drive the
   // count fields directly.
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.outcome        = outcome_ff;
   assign rsp_bus.hit_count      = hits_ff;
   assign rsp_bus.miss_count     = misses_ff;
   assign rsp_bus.eviction_count = evictions_ff;
   assign rsp_bus.last           = last_ff;

endmodule

`default_nettype wire

### hw/rtl/lru_sac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lru_set_assoc_cache_model_assert.svh"

module lru_sac_checker import lru_sac_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [CMD_W-1:0]     req_command,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [OUTCOME_W-1:0] rsp_outcome,
   input wire logic [COUNT_W-1:0]   rsp_hit_count,
   input wire logic [COUNT_W-1:0]   rsp_miss_count,
   input wire logic [COUNT_W-1:0]   rsp_eviction_count,
   input wire logic                 rsp_last
);

   // A stalled response stays valid and keeps its outcome, hit count and last flag.
   `LSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_outcome) && $stable(rsp_hit_count) && $stable(rsp_last))

   // A reported hit has been counted.
   `LSC_ASSERT_IMP(a_hit_counted, rsp_valid && (rsp_outcome == OUTCOME_HIT), rsp_hit_count != '0)

   // A reported eviction is counted both as a miss and as an eviction.
   `LSC_ASSERT_IMP(a_evict_counted, rsp_valid && (rsp_outcome == OUTCOME_EVICT), (rsp_eviction_count != '0) && (rsp_miss_count != '0))

   // An accepted access keeps the block busy in the following cycle.
   `LSC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready && ((req_command == CMD_LOAD) || (req_command == CMD_STORE) || (req_command == CMD_MODIFY)), !req_ready)

endmodule

bind lru_set_assoc_cache_model lru_sac_checker u_lru_sac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_command        (req_bus.command),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_outcome        (rsp_bus.outcome),
   .rsp_hit_count      (rsp_bus.hit_count),
   .rsp_miss_count     (rsp_bus.miss_count),
   .rsp_eviction_count (rsp_bus.eviction_count),
   .rsp_last           (rsp_bus.last)
);

`default_nettype wire

### tb/tb_lru_set_assoc_cache_model.sv
`timescale 1ns / 1ps

module tb_lru_set_assoc_cache_model;
   import lru_sac_pkg::*;

   // Geometry of the block as instantiated (its parameter defaults).
   localparam int unsigned SET_BITS_MAX = 6;
   localparam int unsigned WAYS_MAX     = 8;
   localparam int unsigned LINE_COUNT   = (1 << SET_BITS_MAX) * WAYS_MAX;
   localparam int unsigned AGE_W        = 3;

   // The block has no name for the fourth command code; it is taken and dropped.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // A generous margin after the last expected response lets any access still in flight
   // finish before the registers are written.
   localparam int unsigned DRAIN_CYCLES   = 40;
   // Longest quiet stretch of a correct run is the deliberate response hold-off below,
   // plus the clearing pass after reset; the limit is several times that.
   localparam int unsigned RSP_HOLD       = 300;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [COUNT_W-1:0]   hit_count;
      logic [COUNT_W-1:0]   miss_count;
      logic [COUNT_W-1:0]   eviction_count;
      logic                 last;
   } cache_rsp_type;

   logic clock;
   logic reset;

   lru_sac_req_if req_if ();
   lru_sac_rsp_if rsp_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lru_set_assoc_cache_model dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow of the cache: the configuration as last written and a copy of every line.
   // The tag copy is only ever compared on valid lines, so its reset value is moot.
   // ---------------------------------------------------------------------------------
   logic [SET_BITS_W-1:0]   cfg_set_bits;
   logic [BLOCK_BITS_W-1:0] cfg_block_bits;
   logic [WAYS_W-1:0]       cfg_ways;

   bit                line_valid [LINE_COUNT];
   logic [ADDR_W-1:0] line_tag   [LINE_COUNT];
   logic [AGE_W-1:0]  line_age   [LINE_COUNT];
   logic [COUNT_W-1:0] hits_total;
   logic [COUNT_W-1:0] misses_total;
   logic [COUNT_W-1:0] evictions_total;

   // Expected responses, oldest first.
   cache_rsp_type pending_results [$];

   int unsigned mismatches;
   bit          req_idle_on;
   int unsigned rsp_hold_cycles;
   logic [ADDR_W-1:0] tag_base;

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] age);
      return (age >= AGE_W'(WAYS_MAX - 1)) ? age : age + 1'b1;
   endfunction

   // One lookup against the shadow cache. Returns the outcome code and leaves the lines
   // and the running counts as the block should have them afterwards.
   function automatic logic [OUTCOME_W-1:0] shadow_lookup(input logic [ADDR_W-1:0] addr);
      int unsigned      sb, bb, nw, base, victim, w, i;
      logic [ADDR_W-1:0] tag;
      logic [AGE_W-1:0]  hit_age, oldest;
      bit               found;
      logic [OUTCOME_W-1:0] outcome;

      // Oversized settings are clamped: set bits to SET_BITS_MAX, ways to 1..WAYS_MAX.
      sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
      bb = cfg_block_bits;
      nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways);
      // A shift that reaches the full address width leaves an empty tag.
      tag = (sb + bb >= ADDR_W) ? '0 : (addr >> (sb + bb));
      base = (((addr >> bb) & ((32'd1 << sb) - 1)) % (1 << SET_BITS_MAX)) * WAYS_MAX;

      found = 1'b0;
      for (w = 0; w < nw && !found; w++) begin
         i = base + w;
         if (line_valid[i] && line_tag[i] == tag) begin
            found = 1'b1;
            hit_age = line_age[i];
            // Only the lines that were more recent than the hit line grow older.
            for (int unsigned k = 0; k < nw; k++) begin
               if (base + k != i && line_valid[base + k] && line_age[base + k] < hit_age)
                  line_age[base + k] = age_up(line_age[base + k]);
            end
            line_age[i] = '0;
         end
      end
      if (found) begin
         hits_total = count_up(hits_total);
         return OUTCOME_HIT;
      end

      misses_total = count_up(misses_total);
      outcome = OUTCOME_MISS;
      // The lowest free active way is filled first.
      victim = nw;
      for (w = 0; w < nw && victim == nw; w++) begin
         if (!line_valid[base + w]) victim = w;
      end
      if (victim == nw) begin
         // Set full: evict the oldest line. After a change of ways, ages may repeat,
         // and a tie goes to the lowest way because only a strictly larger age wins.
         victim = 0;
         oldest = '0;
         for (w = 0; w < nw; w++) begin
            if (line_age[base + w] > oldest) begin
               oldest = line_age[base + w];
               victim = w;
            end
         end
         outcome = OUTCOME_EVICT;
         evictions_total = count_up(evictions_total);
      end
      for (w = 0; w < nw; w++) begin
         if (w != victim && line_valid[base + w])
            line_age[base + w] = age_up(line_age[base + w]);
      end
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = tag;
      line_age[base + victim]   = '0;
      return outcome;
   endfunction

   function automatic void expect_result(input logic [OUTCOME_W-1:0] outcome,
                                         input logic last);
      pending_results.push_back('{outcome, hits_total, misses_total, evictions_total, last});
   endfunction

   // Expected responses for one accepted request. The unused command gives none.
   function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                           input logic [ADDR_W-1:0] addr);
      case (cmd)
         CMD_LOAD, CMD_STORE: begin
            expect_result(shadow_lookup(addr), 1'b1);
         end
         CMD_MODIFY: begin
            expect_result(shadow_lookup(addr), 1'b0);
            expect_result(shadow_lookup(addr), 1'b1);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [COUNT_W-1:0] want,
                                  input logic [COUNT_W-1:0] got);
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, field, want,
               got);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------------
   // Request side. Each item waits a random gap first (none while idling is off). The
   // valid line is left high after a transfer so a gapless item follows back to back;
   // it is lowered only at the start of a gap or before the block is left idle.
   // ---------------------------------------------------------------------------------
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.address <= addr;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_request(cmd, addr);
   endtask

   // Stops offering requests and waits until the block has nothing left in flight.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the access edge.
   // The bus is not released here so that back-to-back writes never lower and raise
   // psel in one time step.
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_SET_BITS:   cfg_set_bits   = value[SET_BITS_W-1:0];
         REG_BLOCK_BITS: cfg_block_bits = value[BLOCK_BITS_W-1:0];
         REG_WAYS:       cfg_ways       = value[WAYS_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers once the block is idle. Upper data bits carry junk,
   // which the registers must drop.
   task automatic configure(input int unsigned index_bits, input int unsigned block_bits,
                            input int unsigned way_count);
      drain_block();
      csr_write(REG_SET_BITS, ($urandom << SET_BITS_W) | index_bits);
      csr_write(REG_BLOCK_BITS, ($urandom << BLOCK_BITS_W) | block_bits);
      csr_write(REG_WAYS, ($urandom << WAYS_W) | way_count);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tag_base = $urandom;
   endtask

   // Most addresses are built from a handful of tags and sets under the current layout,
   // so that sets fill up, hit and evict; a quarter are fully random to move every bit.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned sb, bb;
      logic [63:0] tag_part, set_part, offset;
      sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
      bb = cfg_block_bits;
      if ($urandom_range(0, 3) == 0) return $urandom;
      tag_part = 64'(tag_base + $urandom_range(0, 9)) << (sb + bb);
      set_part = 64'($urandom_range(0, 3)) << bb;
      offset   = 64'($urandom) & ((64'd1 << bb) - 64'd1);
      return ADDR_W'(tag_part | set_part | offset);
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 8) return CMD_LOAD;
      if (roll < 16) return CMD_STORE;
      if (roll < 19) return CMD_MODIFY;
      return CMD_UNUSED;
   endfunction

   task automatic run_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         // Idling comes and goes in stretches, with some stretches fully back to back.
         if (n % 40 == 0) req_idle_on = ($urandom_range(0, 3) != 0);
         send_request(pick_command(), pick_address());
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Reset layout: one set, one way, the whole address is the tag.
   task automatic test_reset_layout();
      send_request(CMD_LOAD, 32'h0000_0000);
      send_request(CMD_LOAD, 32'h0000_0000);
      send_request(CMD_STORE, 32'h0000_0001);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_MODIFY, 32'h8000_0000);
      send_request(CMD_UNUSED, 32'h0000_0005);
      send_request(CMD_LOAD, 32'h8000_0000);
   endtask

   // Field extremes: the tag shift reaching the address width, set bits and ways
   // above their maximum, and ways of zero.
   task automatic test_register_extremes();
      configure(6, 31, 8);
      send_request(CMD_LOAD, 32'h0000_0000);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 32'h7FFF_FFFF);
      send_request(CMD_MODIFY, 32'hFFFF_FFFF);
      configure(7, 0, 15);
      send_request(CMD_LOAD, 32'h0000_0FC0);
      send_request(CMD_STORE, 32'hFFFF_FFC0);
      send_request(CMD_MODIFY, 32'h0000_003F);
      configure(7, 26, 0);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_STORE, 32'h0400_0000);
   endtask

   // Four ways in one set: fill, refresh the oldest, then two misses must evict the
   // least recent lines in order.
   task automatic test_lru_replacement();
      configure(1, 4, 4);
      for (int unsigned t = 0; t < 4; t++) send_request(CMD_LOAD, 32'(t) << 5);
      send_request(CMD_LOAD, 32'h0000_0000);
      send_request(CMD_STORE, 32'd4 << 5);
      send_request(CMD_LOAD, 32'd1 << 5);
      send_request(CMD_LOAD, 32'h0000_0000);
   endtask

   // Shrinking the ways at run time hides the upper lines; growing them back brings
   // those lines in again with stale and possibly repeated ages.
   task automatic test_ways_change();
      configure(2, 3, 8);
      run_random(130);
      configure(2, 3, 3);
      run_random(100);
      configure(2, 3, 8);
      run_random(100);
   endtask

   task automatic test_random_layouts();
      for (int unsigned p = 0; p < 7; p++) begin
         configure($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15));
         run_random(90);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming back to back,
   // so the response register fills and the block has to stall its request side.
   task automatic test_backpressure();
      configure(3, 2, 4);
      req_idle_on = 1'b0;
      rsp_hold_cycles = RSP_HOLD;
      for (int unsigned n = 0; n < 60; n++) send_request(pick_command(), pick_address());
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_LOAD;
      req_if.address <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      cfg_set_bits    = SET_BITS_RESET;
      cfg_block_bits  = BLOCK_BITS_RESET;
      cfg_ways        = WAYS_RESET;
      for (int unsigned i = 0; i < LINE_COUNT; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i]   = '0;
         line_age[i]   = '0;
      end
      hits_total      = '0;
      misses_total    = '0;
      evictions_total = '0;
      mismatches      = 0;
      req_idle_on     = 1'b1;
      rsp_hold_cycles = 0;
      tag_base        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_layout();
      test_register_extremes();
      test_lru_replacement();
      test_ways_change();
      test_random_layouts();
      test_backpressure();

      drain_block();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Response side: a random stall before each transfer, in stretches, plus the long
   // hold-off that the backpressure test asks for.
   // ---------------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      int unsigned taken;
      bit          rsp_idle_on;
      rsp_if.ready <= 1'b0;
      taken = 0;
      rsp_idle_on = 1'b1;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 48 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         stall = rsp_idle_on ? $urandom_range(0, 13) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         taken++;
      end
   end

   // Every response transfer is checked field by field against the oldest expectation.
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("responses outstanding", '0, COUNT_W'(1));
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.outcome !== want.outcome)
               report_mismatch("outcome", COUNT_W'(want.outcome), COUNT_W'(rsp_if.outcome));
            if (rsp_if.hit_count !== want.hit_count)
               report_mismatch("hit_count", want.hit_count, rsp_if.hit_count);
            if (rsp_if.miss_count !== want.miss_count)
               report_mismatch("miss_count", want.miss_count, rsp_if.miss_count);
            if (rsp_if.eviction_count !== want.eviction_count)
               report_mismatch("eviction_count", want.eviction_count, rsp_if.eviction_count);
            if (rsp_if.last !== want.last)
               report_mismatch("last", COUNT_W'(want.last), COUNT_W'(rsp_if.last));
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_psel && csr_penable && csr_pready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no transfer for %0d cycles", $realtime, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
